@@ sv/trial_division_prime_test_defines.svh @@
// Assertion macros shared by the trial division prime tester RTL.
// Clocked on aclk, disabled while aresetn is low; no other dependencies.
`ifndef TRIAL_DIVISION_PRIME_TEST_DEFINES_SVH
`define TRIAL_DIVISION_PRIME_TEST_DEFINES_SVH

// Same-cycle implication
`define TDPT_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define TDPT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/tdpt_pkg.sv @@
// Package for the trial division prime tester: widths, defaults, FSM state type
// and the divider status struct. No dependencies.
`timescale 1ns / 1ps

package tdpt_pkg;

    localparam int CAND_W            = 32;  // candidate / tested value field width
    localparam int VALUE_WIDTH_DEF   = 32;  // default working width

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_START,
        ST_DIV,
        ST_DONE
    } tdpt_state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage

@@ sv/tdpt_divider.sv @@
// Restoring radix-2 divider, one quotient bit per cycle, for the prime tester.
// Depends on tdpt_pkg (div_status_t) and trial_division_prime_test_defines.svh.
`timescale 1ns / 1ps
`include "trial_division_prime_test_defines.svh"

module tdpt_divider
    import tdpt_pkg::*;
#(
    parameter int NW = VALUE_WIDTH_DEF
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          start,
    input  logic [NW-1:0] dividend,
    input  logic [NW-1:0] divisor,
    output logic [NW-1:0] quotient,
    output logic [NW-1:0] remainder,
    output div_status_t   status
);

    localparam int CW = $clog2(NW + 1);

    logic [CW-1:0] cnt_reg, cnt_next;
    logic          done_reg, done_next;
    logic [NW-1:0] quo_reg, quo_next;
    logic [NW-1:0] rem_reg, rem_next;
    logic [NW-1:0] dvs_reg, dvs_next;
    logic [NW:0]   trial;
    logic          fits;

    assign trial = {rem_reg, quo_reg[NW-1]};
    assign fits  = (trial >= {1'b0, dvs_reg});

    always_comb begin
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (start) begin
            cnt_next = CW'(NW);
            quo_next = dividend;
            rem_next = '0;
            dvs_next = divisor;
        end else if (cnt_reg != '0) begin
            // shift in the next dividend bit, subtract when it fits
            if (fits) begin
                rem_next = NW'(trial - {1'b0, dvs_reg});
            end else begin
                rem_next = trial[NW-1:0];
            end
            quo_next  = {quo_reg[NW-2:0], fits};
            cnt_next  = cnt_reg - 1'b1;
            done_next = (cnt_reg == CW'(1));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign quotient    = quo_reg;
    assign remainder   = rem_reg;
    assign status.busy = (cnt_reg != '0);
    assign status.done = done_reg;

    `TDPT_ASSERT_NEXT(a_start_busy, start, status.busy, "divider not busy after start")
    `TDPT_ASSERT_NEXT(a_done_idle, status.done, !status.busy, "divider busy after done")
    `TDPT_ASSERT_NOW(a_rem_bound, status.done && (dvs_reg != '0), rem_reg < dvs_reg,
        "remainder not below divisor")

endmodule

@@ sv/trial_division_prime_test.sv @@
// Trial division prime tester: top level with sequencer and output register.
// Depends on tdpt_pkg, tdpt_divider and trial_division_prime_test_defines.svh.
`timescale 1ns / 1ps
`include "trial_division_prime_test_defines.svh"

// Tests each accepted candidate for primality by trial division with divisors
// 2, 3, 4, ... and reports the candidate, a prime flag (m_axis_tuser) and the
// echoed last flag. One shared radix-2 divider yields quotient and remainder of
// candidate / d (NW = min(VALUE_WIDTH, 32)); the scan stops at the first
// divisor that leaves no remainder or once d exceeds the quotient. Each divisor
// goes through start, NW divide steps and a decision, and the block takes the
// next input transaction only once the item is through; the number of divisors
// tried is up to about sqrt(candidate), and 0 and 1 skip the scan.
// s_axis_tready is high only while no candidate is in work; a finished result
// waits in the output register without blocking the input, and only a second
// finished result stalls until the first one is taken.
// Only the low VALUE_WIDTH bits of the candidate are tested and echoed.

module trial_division_prime_test
    import tdpt_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [CAND_W-1:0] s_axis_tdata,   // [31:0] candidate
    input  logic              s_axis_tlast,   // final_in_range
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [CAND_W-1:0] m_axis_tdata,   // [31:0] tested_value
    output logic              m_axis_tuser,   // [0] is_prime
    output logic              m_axis_tlast    // last
);

    localparam int NW = (VALUE_WIDTH < CAND_W) ? VALUE_WIDTH : CAND_W;

    tdpt_state_t   state_reg, state_next;
    logic [NW-1:0] n_reg, n_next;
    logic [NW-1:0] d_reg, d_next;
    logic          last_reg, last_next;
    logic          prime_reg, prime_next;

    logic              out_valid_reg, out_valid_next;
    logic [CAND_W-1:0] out_data_reg, out_data_next;
    logic              out_prime_reg, out_prime_next;
    logic              out_last_reg, out_last_next;

    logic          div_start;
    logic [NW-1:0] div_quo;
    logic [NW-1:0] div_rem;
    div_status_t   div_stat;
    logic          s_fire;

    tdpt_divider #(
        .NW (NW)
    ) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (n_reg),
        .divisor   (d_reg),
        .quotient  (div_quo),
        .remainder (div_rem),
        .status    (div_stat)
    );

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign s_fire        = s_axis_tvalid && s_axis_tready;

    always_comb begin
        state_next     = state_reg;
        n_next         = n_reg;
        d_next         = d_reg;
        last_next      = last_reg;
        prime_next     = prime_reg;
        div_start      = 1'b0;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        out_prime_next = out_prime_reg;
        out_last_next  = out_last_reg;

        // drop the held result once taken
        if (out_valid_reg && m_axis_tready) begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    n_next     = NW'(s_axis_tdata);
                    last_next  = s_axis_tlast;
                    d_next     = NW'(2);
                    prime_next = 1'b0;
                    // zero and one are not prime: skip the scan
                    if (NW'(s_axis_tdata) < NW'(2)) begin
                        state_next = ST_DONE;
                    end else begin
                        state_next = ST_START;
                    end
                end
            end
            ST_START: begin
                div_start  = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV: begin
                if (div_stat.done) begin
                    if (d_reg > div_quo) begin
                        prime_next = 1'b1;
                        state_next = ST_DONE;
                    end else if (div_rem == '0) begin
                        prime_next = 1'b0;
                        state_next = ST_DONE;
                    end else begin
                        d_next     = d_reg + 1'b1;
                        state_next = ST_START;
                    end
                end
            end
            ST_DONE: begin
                // hold until the output register is free
                if (!out_valid_reg || m_axis_tready) begin
                    out_valid_next = 1'b1;
                    out_data_next  = CAND_W'(n_reg);
                    out_prime_next = prime_reg;
                    out_last_next  = last_reg;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
        n_reg         <= n_next;
        d_reg         <= d_next;
        last_reg      <= last_next;
        prime_reg     <= prime_next;
        out_data_reg  <= out_data_next;
        out_prime_reg <= out_prime_next;
        out_last_reg  <= out_last_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_prime_reg;
    assign m_axis_tlast  = out_last_reg;

    `TDPT_ASSERT_NOW(a_small_not_prime, out_valid_reg && (out_data_reg < CAND_W'(2)),
        !out_prime_reg, "zero or one reported prime")
    `TDPT_ASSERT_NOW(a_even_not_prime,
        out_valid_reg && !out_data_reg[0] && (out_data_reg != CAND_W'(2)),
        !out_prime_reg, "even value above two reported prime")
    `TDPT_ASSERT_NOW(a_start_when_free, div_start, !div_stat.busy && (d_reg >= NW'(2)),
        "divider started while busy or with divisor below two")
    `TDPT_ASSERT_NOW(a_done_in_div, div_stat.done, state_reg == ST_DIV,
        "divider finished outside the scan")

endmodule
